@@ design/pvp_pkg.sv @@
// ============================================================================
// pvp_pkg: shared types and arithmetic helpers for the particle velocity push
// Signed Q16.16 words, payload structs, pipeline context and the rounding and
// saturation functions used by the pipeline stages.
// ============================================================================
`default_nettype none

package pvp_pkg;

    // Number format
    localparam int WORD_W     = 32;
    localparam int WIDE_W     = 64;
    localparam int FRAC_W     = 16;
    localparam int ROOT_STEPS = WIDE_W / 2;
    localparam int DIV_STEPS  = WORD_W;
    localparam int CFG_IDX_W  = 3;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [WIDE_W-1:0] wide_t;
    typedef word_t [2:0]              vec3_t;
    typedef wide_t [2:0]              wide3_t;

    localparam word_t       WORD_MAX = 32'sh7FFF_FFFF;
    localparam word_t       WORD_MIN = 32'sh8000_0000;
    localparam word_t       Q_ONE    = 32'sh0001_0000;
    localparam logic [63:0] ONE_Q32  = 64'h0000_0001_0000_0000;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KICK_FACTOR  = 3'd0,
        CFG_ADVANCE_STEP = 3'd1,
        CFG_HALF_STEP    = 3'd2,
        CFG_RELATIVISTIC = 3'd3,
        CFG_THREE_DIM    = 3'd4
    } cfg_reg_t;

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    typedef struct packed {
        word_t vel_x;
        word_t vel_y;
        word_t vel_z;
        word_t pos_x;
        word_t pos_y;
        word_t pos_z;
        word_t efield_x;
        word_t efield_y;
        word_t efield_z;
        word_t bfield_x;
        word_t bfield_y;
        word_t bfield_z;
    } push_data_t;

    typedef struct packed {
        word_t new_vel_x;
        word_t new_vel_y;
        word_t new_vel_z;
        word_t new_pos_x;
        word_t new_pos_y;
        word_t new_pos_z;
        word_t mid_pos_x;
        word_t mid_pos_y;
        word_t mid_pos_z;
        logic  too_fast;
    } result_data_t;

    // Per-particle state carried down the pipeline
    typedef struct packed {
        logic   tf;
        vec3_t  v;
        vec3_t  p;
        vec3_t  ke;
        wide3_t kb;
        vec3_t  u;
        vec3_t  t;
        vec3_t  om;
        vec3_t  n;
    } ctx_t;

    // Saturate a rounded magnitude with its sign to a word
    function automatic word_t sat_mag(input logic neg, input logic [47:0] q);
        word_t res;
        if (!neg && q > 48'h0000_7FFF_FFFF) begin
            res = WORD_MAX;
        end
        else if (neg && q > 48'h0000_8000_0000) begin
            res = WORD_MIN;
        end
        else if (neg) begin
            res = -word_t'(q[31:0]);
        end
        else begin
            res = word_t'(q[31:0]);
        end
        return res;
    endfunction

    // Exact signed 32x32 product
    function automatic wide_t mul_ss(input word_t a, input word_t b);
        wide_t ax;
        wide_t bx;
        ax = WIDE_W'(a);
        bx = WIDE_W'(b);
        return ax * bx;
    endfunction

    // Round a Q32.32 product to Q16.16, half away from zero, saturated
    function automatic word_t mulq(input wide_t p);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] sum;
        neg = p[63];
        mag = neg ? 64'(-p) : 64'(p);
        sum = mag + 64'd32768;
        return sat_mag(neg, sum[63:16]);
    endfunction

    function automatic word_t sat33(input logic signed [32:0] s);
        word_t res;
        if (s[32] != s[31]) begin
            res = s[32] ? WORD_MIN : WORD_MAX;
        end
        else begin
            res = s[31:0];
        end
        return res;
    endfunction

    function automatic word_t sat34(input logic signed [33:0] s);
        word_t res;
        if (s[33:31] == 3'b000 || s[33:31] == 3'b111) begin
            res = s[31:0];
        end
        else begin
            res = s[33] ? WORD_MIN : WORD_MAX;
        end
        return res;
    endfunction

    function automatic word_t adds(input word_t a, input word_t b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        return sat33(s);
    endfunction

    function automatic word_t subs(input word_t a, input word_t b);
        logic signed [32:0] s;
        s = 33'(a) - 33'(b);
        return sat33(s);
    endfunction

    // Q16.16 word placed as a Q32.32 dividend (value times one)
    function automatic wide_t scale_up(input word_t a);
        return {{FRAC_W{a[WORD_W-1]}}, a, {FRAC_W{1'b0}}};
    endfunction

endpackage

`default_nettype wire

@@ design/pvp_rootdiv.sv @@
// ============================================================================
// pvp_rootdiv: pipelined square root followed by a three-lane divider
// Takes the floor square root of a 64-bit argument, one result bit per stage,
// then divides three signed dividends by that root (or by a given divisor),
// one quotient bit per stage, rounded half away from zero and saturated.
// ============================================================================
`default_nettype none

module pvp_rootdiv (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_vld,
    input  pvp_pkg::ctx_t   in_ctx,
    input  logic            root_en,
    input  logic [63:0]     arg,
    input  logic [31:0]     den,
    input  pvp_pkg::wide3_t num,
    output logic            out_vld,
    output pvp_pkg::ctx_t   out_ctx,
    output pvp_pkg::vec3_t  quot
);
    import pvp_pkg::*;

    typedef struct packed {
        ctx_t              ctx;
        logic              root_en;
        logic [63:0]       x;
        logic [33:0]       rem;
        logic [31:0]       root;
        logic [31:0]       den;
        logic [2:0]        neg;
        logic [2:0][63:0]  mag;
    } root_stage_t;

    typedef struct packed {
        ctx_t              ctx;
        logic [31:0]       den;
        logic [2:0]        neg;
        logic [2:0]        ovf;
        logic [2:0][31:0]  lo;
        logic [2:0][31:0]  rem;
        logic [2:0][31:0]  quo;
    } div_stage_t;

    root_stage_t root_reg [0:ROOT_STEPS];
    logic        root_vld_reg [0:ROOT_STEPS];
    div_stage_t  div_reg [0:DIV_STEPS];
    logic        div_vld_reg [0:DIV_STEPS];

    root_stage_t root_next;
    div_stage_t  prep_next;
    vec3_t       quot_reg;
    vec3_t       quot_next;
    ctx_t        ctx_out_reg;
    logic        out_vld_reg;

    // Capture the request: split dividends into sign and magnitude
    always_comb
    begin
        root_next.ctx     = in_ctx;
        root_next.root_en = root_en;
        root_next.x       = arg;
        root_next.rem     = '0;
        root_next.root    = '0;
        root_next.den     = den;
        for (int i = 0; i < 3; i++)
        begin
            root_next.neg[i] = num[i][63];
            root_next.mag[i] = num[i][63] ? 64'(-num[i]) : 64'(num[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            root_vld_reg[0] <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            root_reg[0] <= root_next;
        end
    end

    // Square root: one result bit per stage, two argument bits consumed
    for (genvar k = 0; k < ROOT_STEPS; k++)
    begin : g_root
        localparam int HI = 2 * (ROOT_STEPS - 1 - k) + 1;
        logic [35:0] sh;
        logic [35:0] trial;
        logic [35:0] diff;
        logic        ge;
        root_stage_t step_next;

        always_comb
        begin
            sh    = {root_reg[k].rem, root_reg[k].x[HI -: 2]};
            trial = {2'b00, root_reg[k].root, 2'b01};
            ge    = sh >= trial;
            diff  = sh - trial;
            step_next      = root_reg[k];
            step_next.rem  = ge ? diff[33:0] : sh[33:0];
            step_next.root = {root_reg[k].root[30:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                root_vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                root_vld_reg[k+1] <= root_vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[k+1] <= step_next;
            end
        end
    end

    // Pick the divisor, add half of it for rounding, flag quotient overflow
    always_comb
    begin
        logic [31:0] d;
        logic [63:0] m;
        d = root_reg[ROOT_STEPS].root_en ? root_reg[ROOT_STEPS].root
                                         : root_reg[ROOT_STEPS].den;
        prep_next.ctx = root_reg[ROOT_STEPS].ctx;
        prep_next.den = d;
        prep_next.neg = root_reg[ROOT_STEPS].neg;
        for (int i = 0; i < 3; i++)
        begin
            m = root_reg[ROOT_STEPS].mag[i] + {33'b0, d[31:1]};
            prep_next.ovf[i] = m[63:32] >= d;
            prep_next.rem[i] = m[63:32];
            prep_next.lo[i]  = m[31:0];
            prep_next.quo[i] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            div_vld_reg[0] <= root_vld_reg[ROOT_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg[0] <= prep_next;
        end
    end

    // Restoring division: one quotient bit per stage on each lane
    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        localparam int B = DIV_STEPS - 1 - j;
        div_stage_t step_next;

        always_comb
        begin
            logic [32:0] r33;
            logic [32:0] dd;
            logic [32:0] diff;
            logic        ge;
            step_next = div_reg[j];
            dd = {1'b0, div_reg[j].den};
            for (int i = 0; i < 3; i++)
            begin
                r33  = {div_reg[j].rem[i], div_reg[j].lo[i][B]};
                ge   = r33 >= dd;
                diff = r33 - dd;
                step_next.rem[i] = ge ? diff[31:0] : r33[31:0];
                step_next.quo[i] = {div_reg[j].quo[i][30:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                div_vld_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                div_vld_reg[j+1] <= div_vld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                div_reg[j+1] <= step_next;
            end
        end
    end

    // Apply sign and saturate
    always_comb
    begin
        logic [47:0] q48;
        for (int i = 0; i < 3; i++)
        begin
            q48 = div_reg[DIV_STEPS].ovf[i] ? '1 : {16'h0000, div_reg[DIV_STEPS].quo[i]};
            quot_next[i] = sat_mag(div_reg[DIV_STEPS].neg[i], q48);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= div_vld_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quot_reg    <= quot_next;
            ctx_out_reg <= div_reg[DIV_STEPS].ctx;
        end
    end

    assign out_vld = out_vld_reg;
    assign out_ctx = ctx_out_reg;
    assign quot    = quot_reg;

endmodule

`default_nettype wire

@@ design/particle_velocity_push.sv @@
// ============================================================================
// particle_velocity_push: pipelined implicit Boris particle pusher
// Pushes one charged particle per request through an electric half kick, an
// implicit magnetic rotation and a position advance, in signed Q16.16.
// ============================================================================
//
// The pusher takes one particle per clock unless the pipeline is held; the
// whole pipeline holds while a finished result waits on result_ready, so
// push_ready follows result_ready whenever the output register is full. It
// is built from four root-and-divide units of 67 stages each (32 square-root
// stages, 32 quotient stages, and three stages around them) plus 13 stages of
// multiply, round and saturate. Configuration registers are read live by the
// stages that use them: write them only with the pipeline empty. A particle
// at or above light speed in relativistic mode comes back unchanged with
// too_fast set.
`default_nettype none

module particle_velocity_push (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  pvp_pkg::cfg_index_t   cfg_index,
    input  pvp_pkg::word_t        cfg_data,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  pvp_pkg::push_data_t   push_data,
    output logic                  result_valid,
    input  logic                  result_ready,
    output pvp_pkg::result_data_t result_data
);
    import pvp_pkg::*;

    // Configuration registers
    word_t       kick_factor_reg;
    logic [30:0] advance_step_reg;
    logic [30:0] half_step_reg;
    logic        relativistic_reg;
    logic        three_dim_reg;

    logic adv;

    // Stage valids
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg;
    logic s6_vld_reg, s7_vld_reg, s8_vld_reg, s9_vld_reg, s10_vld_reg;
    logic s11_vld_reg, s12_vld_reg, s13_vld_reg;

    // Stage payloads
    ctx_t   s1_ctx_reg, s1_ctx_next;
    wide3_t s1_ke_p_reg, s1_ke_p_next;
    wide3_t s1_vsq_reg, s1_vsq_next;
    ctx_t   s2_ctx_reg, s2_ctx_next;
    ctx_t   s3_ctx_reg, s3_ctx_next;
    wide3_t s3_tsq_reg, s3_tsq_next;
    ctx_t   s4_ctx_reg, s4_ctx_next;
    wide3_t s4_oo_p_reg, s4_oo_p_next;
    wide3_t s4_to_p_reg, s4_to_p_next;
    wide3_t s4_ca_p_reg, s4_ca_p_next;
    wide3_t s4_cb_p_reg, s4_cb_p_next;
    ctx_t   s5_ctx_reg, s5_ctx_next;
    vec3_t  s5_oo_reg, s5_oo_next;
    vec3_t  s5_to_reg, s5_to_next;
    vec3_t  s5_ca_reg, s5_ca_next;
    vec3_t  s5_cb_reg, s5_cb_next;
    ctx_t   s6_ctx_reg, s6_ctx_next;
    word_t  s6_d_reg, s6_d_next;
    word_t  s6_udo_reg, s6_udo_next;
    vec3_t  s6_cr_reg, s6_cr_next;
    ctx_t   s7_ctx_reg, s7_ctx_next;
    word_t  s7_d_reg, s7_d_next;
    vec3_t  s7_cr_reg, s7_cr_next;
    wide3_t s7_uo_p_reg, s7_uo_p_next;
    ctx_t   s8_ctx_reg, s8_ctx_next;
    word_t  s8_d_reg, s8_d_next;
    vec3_t  s8_num_reg, s8_num_next;
    ctx_t   s9_ctx_reg, s9_ctx_next;
    ctx_t   s10_ctx_reg, s10_ctx_next;
    wide3_t s10_nsq_reg, s10_nsq_next;
    ctx_t   s11_ctx_reg, s11_ctx_next;
    ctx_t   s12_ctx_reg, s12_ctx_next;
    wide3_t s12_pa_p_reg, s12_pa_p_next;
    wide3_t s12_ph_p_reg, s12_ph_p_next;
    result_data_t s13_res_reg, s13_res_next;

    // Root-and-divide unit connections
    ctx_t        u1_ctx, u2_ctx, u3_ctx, u4_ctx;
    logic [63:0] u1_arg, u2_arg, u4_arg;
    wide3_t      u1_num, u2_num, u3_num, u4_num;
    logic        u1_vld, u2_vld, u3_vld, u4_vld;
    ctx_t        u1_out_ctx, u2_out_ctx, u3_out_ctx, u4_out_ctx;
    vec3_t       u1_quot, u2_quot, u3_quot, u4_quot;

    // Hold the whole pipeline while the output register is stalled
    assign adv          = !s13_vld_reg || result_ready;
    assign push_ready   = adv;
    assign result_valid = s13_vld_reg;
    assign result_data  = s13_res_reg;
    assign cfg_ready    = 1'b1;

    // Configuration writes; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kick_factor_reg  <= '0;
            advance_step_reg <= '0;
            half_step_reg    <= '0;
            relativistic_reg <= 1'b0;
            three_dim_reg    <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_KICK_FACTOR:  kick_factor_reg  <= cfg_data;
                CFG_ADVANCE_STEP: advance_step_reg <= cfg_data[30:0];
                CFG_HALF_STEP:    half_step_reg    <= cfg_data[30:0];
                CFG_RELATIVISTIC: relativistic_reg <= cfg_data[0];
                CFG_THREE_DIM:    three_dim_reg    <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Stage 1: unpack, field products with the kick factor, velocity squares
    always_comb
    begin
        vec3_t e;
        vec3_t b;
        s1_ctx_next = '0;
        s1_ctx_next.v[0] = push_data.vel_x;
        s1_ctx_next.v[1] = push_data.vel_y;
        s1_ctx_next.v[2] = push_data.vel_z;
        s1_ctx_next.p[0] = push_data.pos_x;
        s1_ctx_next.p[1] = push_data.pos_y;
        s1_ctx_next.p[2] = push_data.pos_z;
        e[0] = push_data.efield_x;
        e[1] = push_data.efield_y;
        e[2] = push_data.efield_z;
        b[0] = push_data.bfield_x;
        b[1] = push_data.bfield_y;
        b[2] = push_data.bfield_z;
        for (int i = 0; i < 3; i++)
        begin
            s1_ctx_next.kb[i] = mul_ss(kick_factor_reg, b[i]);
            s1_ke_p_next[i]   = mul_ss(kick_factor_reg, e[i]);
            s1_vsq_next[i]    = mul_ss(s1_ctx_next.v[i], s1_ctx_next.v[i]);
        end
    end

    // Unit 1 request: inverse Lorentz factor root, then v / root
    always_comb
    begin
        logic [63:0] v2;
        v2 = 64'(s1_vsq_reg[0]) + 64'(s1_vsq_reg[1]) + 64'(s1_vsq_reg[2]);
        u1_ctx    = s1_ctx_reg;
        u1_ctx.tf = relativistic_reg && (v2 >= ONE_Q32);
        u1_arg    = ONE_Q32 - v2;
        for (int i = 0; i < 3; i++)
        begin
            u1_ctx.ke[i] = mulq(s1_ke_p_reg[i]);
            u1_num[i]    = scale_up(s1_ctx_reg.v[i]);
        end
    end

    pvp_rootdiv u_rd1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (s1_vld_reg),
        .in_ctx  (u1_ctx),
        .root_en (1'b1),
        .arg     (u1_arg),
        .den     (Q_ONE),
        .num     (u1_num),
        .out_vld (u1_vld),
        .out_ctx (u1_out_ctx),
        .quot    (u1_quot)
    );

    // Stage 2: proper velocity and electric half kick
    always_comb
    begin
        s2_ctx_next = u1_out_ctx;
        for (int i = 0; i < 3; i++)
        begin
            s2_ctx_next.u[i] = (relativistic_reg && !u1_out_ctx.tf) ? u1_quot[i]
                                                                    : u1_out_ctx.v[i];
            s2_ctx_next.t[i] = adds(s2_ctx_next.u[i], u1_out_ctx.ke[i]);
        end
    end

    // Stage 3: squares of the kicked velocity
    always_comb
    begin
        s3_ctx_next = s2_ctx_reg;
        for (int i = 0; i < 3; i++)
        begin
            s3_tsq_next[i] = mul_ss(s2_ctx_reg.t[i], s2_ctx_reg.t[i]);
        end
    end

    // Unit 2 request: Lorentz factor root, then omega = kick * B / gamma (kick * B when not relativistic)
    always_comb
    begin
        u2_ctx = s3_ctx_reg;
        u2_arg = ONE_Q32 + 64'(s3_tsq_reg[0]) + 64'(s3_tsq_reg[1]) + 64'(s3_tsq_reg[2]);
        u2_num = s3_ctx_reg.kb;
    end

    pvp_rootdiv u_rd2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (s3_vld_reg),
        .in_ctx  (u2_ctx),
        .root_en (relativistic_reg),
        .arg     (u2_arg),
        .den     (Q_ONE),
        .num     (u2_num),
        .out_vld (u2_vld),
        .out_ctx (u2_out_ctx),
        .quot    (u2_quot)
    );

    // Stage 4: omega products for the denominator, dot and cross products
    always_comb
    begin
        vec3_t t;
        vec3_t om;
        t  = u2_out_ctx.t;
        om = u2_quot;
        s4_ctx_next    = u2_out_ctx;
        s4_ctx_next.om = om;
        for (int i = 0; i < 3; i++)
        begin
            s4_oo_p_next[i] = mul_ss(om[i], om[i]);
            s4_to_p_next[i] = mul_ss(t[i], om[i]);
        end
        s4_ca_p_next[0] = mul_ss(t[1], om[2]);
        s4_cb_p_next[0] = mul_ss(t[2], om[1]);
        s4_ca_p_next[1] = mul_ss(t[2], om[0]);
        s4_cb_p_next[1] = mul_ss(t[0], om[2]);
        s4_ca_p_next[2] = mul_ss(t[0], om[1]);
        s4_cb_p_next[2] = mul_ss(t[1], om[0]);
    end

    // Stage 5: round the products
    always_comb
    begin
        s5_ctx_next = s4_ctx_reg;
        for (int i = 0; i < 3; i++)
        begin
            s5_oo_next[i] = mulq(s4_oo_p_reg[i]);
            s5_to_next[i] = mulq(s4_to_p_reg[i]);
            s5_ca_next[i] = mulq(s4_ca_p_reg[i]);
            s5_cb_next[i] = mulq(s4_cb_p_reg[i]);
        end
    end

    // Stage 6: denominator, dot product and cross product
    always_comb
    begin
        s6_ctx_next = s5_ctx_reg;
        s6_d_next   = adds(adds(adds(Q_ONE, s5_oo_reg[0]), s5_oo_reg[1]), s5_oo_reg[2]);
        s6_udo_next = adds(adds(s5_to_reg[0], s5_to_reg[1]), s5_to_reg[2]);
        for (int i = 0; i < 3; i++)
        begin
            s6_cr_next[i] = subs(s5_ca_reg[i], s5_cb_reg[i]);
        end
    end

    // Stage 7: dot product times omega
    always_comb
    begin
        s7_ctx_next = s6_ctx_reg;
        s7_d_next   = s6_d_reg;
        s7_cr_next  = s6_cr_reg;
        for (int i = 0; i < 3; i++)
        begin
            s7_uo_p_next[i] = mul_ss(s6_udo_reg, s6_ctx_reg.om[i]);
        end
    end

    // Stage 8: rotation numerator
    always_comb
    begin
        s8_ctx_next = s7_ctx_reg;
        s8_d_next   = s7_d_reg;
        for (int i = 0; i < 3; i++)
        begin
            s8_num_next[i] = adds(s7_ctx_reg.t[i], adds(s7_cr_reg[i], mulq(s7_uo_p_reg[i])));
        end
    end

    // Unit 3 request: average velocity = numerator / denominator
    always_comb
    begin
        u3_ctx = s8_ctx_reg;
        for (int i = 0; i < 3; i++)
        begin
            u3_num[i] = scale_up(s8_num_reg[i]);
        end
    end

    pvp_rootdiv u_rd3 (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (s8_vld_reg),
        .in_ctx  (u3_ctx),
        .root_en (1'b0),
        .arg     (64'h0),
        .den     (s8_d_reg),
        .num     (u3_num),
        .out_vld (u3_vld),
        .out_ctx (u3_out_ctx),
        .quot    (u3_quot)
    );

    // Stage 9: new velocity = 2 * avg - old
    always_comb
    begin
        logic signed [33:0] s;
        s9_ctx_next = u3_out_ctx;
        for (int i = 0; i < 3; i++)
        begin
            s = {u3_quot[i][31], u3_quot[i], 1'b0}
                - {{2{u3_out_ctx.u[i][31]}}, u3_out_ctx.u[i]};
            s9_ctx_next.n[i] = sat34(s);
        end
    end

    // Stage 10: squares of the new velocity
    always_comb
    begin
        s10_ctx_next = s9_ctx_reg;
        for (int i = 0; i < 3; i++)
        begin
            s10_nsq_next[i] = mul_ss(s9_ctx_reg.n[i], s9_ctx_reg.n[i]);
        end
    end

    // Unit 4 request: Lorentz factor of the new velocity, then n / gamma
    always_comb
    begin
        u4_ctx = s10_ctx_reg;
        u4_arg = ONE_Q32 + 64'(s10_nsq_reg[0]) + 64'(s10_nsq_reg[1]) + 64'(s10_nsq_reg[2]);
        for (int i = 0; i < 3; i++)
        begin
            u4_num[i] = scale_up(s10_ctx_reg.n[i]);
        end
    end

    pvp_rootdiv u_rd4 (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (s10_vld_reg),
        .in_ctx  (u4_ctx),
        .root_en (1'b1),
        .arg     (u4_arg),
        .den     (Q_ONE),
        .num     (u4_num),
        .out_vld (u4_vld),
        .out_ctx (u4_out_ctx),
        .quot    (u4_quot)
    );

    // Stage 11: pick the final velocity
    always_comb
    begin
        s11_ctx_next = u4_out_ctx;
        if (relativistic_reg)
        begin
            s11_ctx_next.n = u4_quot;
        end
    end

    // Stage 12: velocity times the step lengths
    always_comb
    begin
        s12_ctx_next = s11_ctx_reg;
        for (int i = 0; i < 3; i++)
        begin
            s12_pa_p_next[i] = mul_ss(s11_ctx_reg.n[i], word_t'({1'b0, advance_step_reg}));
            s12_ph_p_next[i] = mul_ss(s11_ctx_reg.n[i], word_t'({1'b0, half_step_reg}));
        end
    end

    // Stage 13: advance positions, echo the particle when too fast
    always_comb
    begin
        vec3_t pn;
        vec3_t pm;
        for (int i = 0; i < 3; i++)
        begin
            pn[i] = adds(s12_ctx_reg.p[i], mulq(s12_pa_p_reg[i]));
            pm[i] = adds(s12_ctx_reg.p[i], mulq(s12_ph_p_reg[i]));
        end
        if (!three_dim_reg)
        begin
            pn[2] = s12_ctx_reg.p[2];
            pm[2] = mulq(s12_ph_p_reg[2]);
        end
        if (s12_ctx_reg.tf)
        begin
            s13_res_next.new_vel_x = s12_ctx_reg.v[0];
            s13_res_next.new_vel_y = s12_ctx_reg.v[1];
            s13_res_next.new_vel_z = s12_ctx_reg.v[2];
            s13_res_next.new_pos_x = s12_ctx_reg.p[0];
            s13_res_next.new_pos_y = s12_ctx_reg.p[1];
            s13_res_next.new_pos_z = s12_ctx_reg.p[2];
            s13_res_next.mid_pos_x = s12_ctx_reg.p[0];
            s13_res_next.mid_pos_y = s12_ctx_reg.p[1];
            s13_res_next.mid_pos_z = s12_ctx_reg.p[2];
        end
        else
        begin
            s13_res_next.new_vel_x = s12_ctx_reg.n[0];
            s13_res_next.new_vel_y = s12_ctx_reg.n[1];
            s13_res_next.new_vel_z = s12_ctx_reg.n[2];
            s13_res_next.new_pos_x = pn[0];
            s13_res_next.new_pos_y = pn[1];
            s13_res_next.new_pos_z = pn[2];
            s13_res_next.mid_pos_x = pm[0];
            s13_res_next.mid_pos_y = pm[1];
            s13_res_next.mid_pos_z = pm[2];
        end
        s13_res_next.too_fast = s12_ctx_reg.tf;
    end

    // Advance stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            s6_vld_reg  <= 1'b0;
            s7_vld_reg  <= 1'b0;
            s8_vld_reg  <= 1'b0;
            s9_vld_reg  <= 1'b0;
            s10_vld_reg <= 1'b0;
            s11_vld_reg <= 1'b0;
            s12_vld_reg <= 1'b0;
            s13_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg  <= push_valid;
            s2_vld_reg  <= u1_vld;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= u2_vld;
            s5_vld_reg  <= s4_vld_reg;
            s6_vld_reg  <= s5_vld_reg;
            s7_vld_reg  <= s6_vld_reg;
            s8_vld_reg  <= s7_vld_reg;
            s9_vld_reg  <= u3_vld;
            s10_vld_reg <= s9_vld_reg;
            s11_vld_reg <= u4_vld;
            s12_vld_reg <= s11_vld_reg;
            s13_vld_reg <= s12_vld_reg;
        end
    end

    // Advance stage payloads
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ctx_reg   <= s1_ctx_next;
            s1_ke_p_reg  <= s1_ke_p_next;
            s1_vsq_reg   <= s1_vsq_next;
            s2_ctx_reg   <= s2_ctx_next;
            s3_ctx_reg   <= s3_ctx_next;
            s3_tsq_reg   <= s3_tsq_next;
            s4_ctx_reg   <= s4_ctx_next;
            s4_oo_p_reg  <= s4_oo_p_next;
            s4_to_p_reg  <= s4_to_p_next;
            s4_ca_p_reg  <= s4_ca_p_next;
            s4_cb_p_reg  <= s4_cb_p_next;
            s5_ctx_reg   <= s5_ctx_next;
            s5_oo_reg    <= s5_oo_next;
            s5_to_reg    <= s5_to_next;
            s5_ca_reg    <= s5_ca_next;
            s5_cb_reg    <= s5_cb_next;
            s6_ctx_reg   <= s6_ctx_next;
            s6_d_reg     <= s6_d_next;
            s6_udo_reg   <= s6_udo_next;
            s6_cr_reg    <= s6_cr_next;
            s7_ctx_reg   <= s7_ctx_next;
            s7_d_reg     <= s7_d_next;
            s7_cr_reg    <= s7_cr_next;
            s7_uo_p_reg  <= s7_uo_p_next;
            s8_ctx_reg   <= s8_ctx_next;
            s8_d_reg     <= s8_d_next;
            s8_num_reg   <= s8_num_next;
            s9_ctx_reg   <= s9_ctx_next;
            s10_ctx_reg  <= s10_ctx_next;
            s10_nsq_reg  <= s10_nsq_next;
            s11_ctx_reg  <= s11_ctx_next;
            s12_ctx_reg  <= s12_ctx_next;
            s12_pa_p_reg <= s12_pa_p_next;
            s12_ph_p_reg <= s12_ph_p_next;
            s13_res_reg  <= s13_res_next;
        end
    end

endmodule

`default_nettype wire
